// ----- rtl/cln_pkg.sv -----
// Package for the command line normalizer: character codes, slot layout of
// one burst of output words, and the neighbor rule function. No dependencies.
`default_nettype none

package cln_pkg;

  localparam logic [7:0] CharHash  = 8'h23;
  localparam logic [7:0] CharLt    = 8'h3C;
  localparam logic [7:0] CharGt    = 8'h3E;
  localparam logic [7:0] CharPipe  = 8'h7C;
  localparam logic [7:0] CharAmp   = 8'h26;
  localparam logic [7:0] CharSemi  = 8'h3B;
  localparam logic [7:0] CharNl    = 8'h0A;
  localparam logic [7:0] CharSpace = 8'h20;

  // One input word yields at most seven output words, each in a fixed slot.
  localparam int unsigned NumSlots = 7;
  localparam int unsigned SlotIdxW = $clog2(NumSlots);

  localparam int unsigned SlotPre1  = 0;
  localparam int unsigned SlotChar1 = 1;
  localparam int unsigned SlotPost1 = 2;
  localparam int unsigned SlotPre2  = 3;
  localparam int unsigned SlotChar2 = 4;
  localparam int unsigned SlotPost2 = 5;
  localparam int unsigned SlotNl    = 6;

  typedef struct packed {
    logic pre;
    logic emit;
    logic post;
  } dec_t;

  typedef struct packed {
    logic [NumSlots-1:0]       en;
    logic [NumSlots-1:0][7:0]  bytes;
    logic                      mark;
  } burst_t;

  // Decides what a held character becomes, given its raw predecessor and
  // its successor.
  function automatic dec_t decide(input logic [7:0] c, input logic [7:0] p,
                                  input logic [7:0] s, input logic first,
                                  input logic last);
    dec_t r;
    r = '0;
    if (c == CharSpace) begin
      r.emit = !(first || (p == CharSpace));
    end else if (c inside {CharLt, CharSemi}) begin
      r.emit = 1'b1;
      r.pre  = !first && (p != CharSpace);
      r.post = !last && (s != CharSpace);
    end else if (c inside {CharGt, CharPipe}) begin
      r.emit = 1'b1;
      r.pre  = !first && (p != CharSpace) && (p != c);
      r.post = !last && (s != CharSpace) && (s != c);
    end else if (c == CharAmp) begin
      r.emit = 1'b1;
      r.pre  = !first && (p != CharSpace) && (last || (s == CharAmp));
      r.post = !first && !last && (s != CharSpace) && (p == CharAmp);
    end else begin
      r.emit = 1'b1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/cln_if.sv -----
// Valid/ready channel interfaces for the command line normalizer.
// Depends on nothing.
`default_nettype none

interface cln_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface cln_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

`default_nettype wire

// ----- rtl/cln_front.sv -----
// Line state and decode: turns one accepted input word into a burst of
// output slots. Depends on cln_pkg.
`default_nettype none

module cln_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            accept_i,
  input  wire logic [7:0]      in_byte_i,
  input  wire logic            in_last_i,
  output cln_pkg::burst_t      burst_o
);

  logic [7:0] held_char_q, held_char_d;
  logic       held_valid_q, held_valid_d;
  logic       held_first_q, held_first_d;
  logic [7:0] prev_char_q, prev_char_d;
  logic       comment_q, comment_d;
  logic       last_nl_q, last_nl_d;

  cln_pkg::dec_t d1;
  cln_pkg::dec_t d2;
  logic          mark_hash;
  logic          need_nl;

  always_comb begin
    held_char_d  = held_char_q;
    held_valid_d = held_valid_q;
    held_first_d = held_first_q;
    prev_char_d  = prev_char_q;
    comment_d    = comment_q;
    last_nl_d    = last_nl_q;
    d1           = '0;
    d2           = '0;
    mark_hash    = 1'b0;
    need_nl      = 1'b0;

    if (!comment_q) begin
      if (held_valid_q) begin
        d1 = cln_pkg::decide(held_char_q, prev_char_q, in_byte_i, held_first_q, 1'b0);
        if (d1.emit) begin
          last_nl_d = !d1.post && (held_char_q == cln_pkg::CharNl);
        end
        prev_char_d  = held_char_q;
        held_first_d = 1'b0;
        held_valid_d = 1'b0;
      end
      if (in_byte_i == cln_pkg::CharHash) begin
        comment_d = 1'b1;
        mark_hash = held_valid_q && (held_char_q == cln_pkg::CharNl);
      end else begin
        held_char_d  = in_byte_i;
        held_valid_d = 1'b1;
      end
    end

    if (in_last_i) begin
      if (held_valid_d) begin
        d2 = cln_pkg::decide(held_char_d, prev_char_d, 8'h00, held_first_d, 1'b1);
        if (d2.emit) begin
          last_nl_d = !d2.post && (held_char_d == cln_pkg::CharNl);
        end
      end
      need_nl = !last_nl_d;
    end

    burst_o.en[cln_pkg::SlotPre1]     = d1.pre;
    burst_o.en[cln_pkg::SlotChar1]    = d1.emit;
    burst_o.en[cln_pkg::SlotPost1]    = d1.post;
    burst_o.en[cln_pkg::SlotPre2]     = d2.pre;
    burst_o.en[cln_pkg::SlotChar2]    = d2.emit;
    burst_o.en[cln_pkg::SlotPost2]    = d2.post;
    burst_o.en[cln_pkg::SlotNl]       = need_nl;
    burst_o.bytes[cln_pkg::SlotPre1]  = cln_pkg::CharSpace;
    burst_o.bytes[cln_pkg::SlotChar1] = held_char_q;
    burst_o.bytes[cln_pkg::SlotPost1] = cln_pkg::CharSpace;
    burst_o.bytes[cln_pkg::SlotPre2]  = cln_pkg::CharSpace;
    burst_o.bytes[cln_pkg::SlotChar2] = held_char_d;
    burst_o.bytes[cln_pkg::SlotPost2] = cln_pkg::CharSpace;
    burst_o.bytes[cln_pkg::SlotNl]    = cln_pkg::CharNl;
    burst_o.mark                      = in_last_i || mark_hash;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_char_q  <= 8'h00;
      held_valid_q <= 1'b0;
      held_first_q <= 1'b1;
      prev_char_q  <= 8'h00;
      comment_q    <= 1'b0;
      last_nl_q    <= 1'b0;
    end else if (accept_i) begin
      if (in_last_i) begin
        held_char_q  <= 8'h00;
        held_valid_q <= 1'b0;
        held_first_q <= 1'b1;
        prev_char_q  <= 8'h00;
        comment_q    <= 1'b0;
        last_nl_q    <= 1'b0;
      end else begin
        held_char_q  <= held_char_d;
        held_valid_q <= held_valid_d;
        held_first_q <= held_first_d;
        prev_char_q  <= prev_char_d;
        comment_q    <= comment_d;
        last_nl_q    <= last_nl_d;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/cln_serial.sv -----
// Burst register and output register: sends the filled slots of a burst
// one word per cycle while the output is not stalled, lowest slot first. Depends on cln_pkg and cln_if.
`default_nettype none

module cln_serial (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             accept_i,
  input  wire cln_pkg::burst_t  burst_i,
  output logic                  space_o,
  cln_out_if.source             out_o
);

  logic [cln_pkg::NumSlots-1:0]      en_q, en_d;
  logic [cln_pkg::NumSlots-1:0][7:0] bytes_q;
  logic                              mark_q;

  logic                              out_valid_q;
  logic [7:0]                        out_byte_q;
  logic                              out_last_q;

  logic [cln_pkg::SlotIdxW-1:0]      idx;
  logic [cln_pkg::NumSlots-1:0]      pick;
  logic [cln_pkg::NumSlots-1:0]      rest;
  logic                              load;

  always_comb begin
    idx  = '0;
    pick = '0;
    for (int i = cln_pkg::NumSlots - 1; i >= 0; i--) begin
      if (en_q[i]) begin
        idx = cln_pkg::SlotIdxW'(i);
      end
    end
    pick[idx] = 1'b1;
    rest      = en_q & ~pick;
    load      = (|en_q) && (!out_valid_q || out_o.ready);
    space_o   = !(|en_q) || (load && (rest == '0));
    if (accept_i) begin
      en_d = burst_i.en;
    end else if (load) begin
      en_d = rest;
    end else begin
      en_d = en_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      en_q <= en_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      bytes_q <= burst_i.bytes;
      mark_q  <= burst_i.mark;
    end
    if (load) begin
      out_byte_q <= bytes_q[idx];
      out_last_q <= mark_q && (rest == '0);
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.out_byte = out_byte_q;
  assign out_o.out_last = out_last_q;

endmodule

`default_nettype wire

// ----- rtl/command_line_normalizer.sv -----
// Top level of the command line normalizer: line decode plus word serializer.
// Depends on cln_pkg, cln_if, cln_front and cln_serial.
//
//   port    direction  payload             role
//   in_i    sink       in_byte, in_last    raw line, one character per word
//   out_o   source     out_byte, out_last  normalized line, one per word
//
// An input word yields at most seven output words, possibly none, and it
// occupies the block until each of them has been sent.
// The burst register frees up when its last slot moves into the output
// register, so the next input word is taken while that word waits.
// Reset clears the line state and all valid flags; a stalled output simply
// holds the burst and input ready stays low until the burst drains.
`default_nettype none

module command_line_normalizer (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  cln_in_if.sink    in_i,
  cln_out_if.source out_o
);

  cln_pkg::burst_t burst;
  logic            space;
  logic            accept;

  assign in_i.ready = space;
  assign accept     = in_i.valid && space;

  cln_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_byte_i (in_i.in_byte),
    .in_last_i (in_i.in_last),
    .burst_o   (burst)
  );

  cln_serial u_serial (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .burst_i  (burst),
    .space_o  (space),
    .out_o    (out_o)
  );

endmodule

`default_nettype wire

// ----- tb/sv/command_line_normalizer_test.sv -----
// Testbench for command_line_normalizer: sends raw command lines one word at a time
// and checks each normalized output word against a line-level predictor.
// Depends on cln_pkg, cln_if and the command_line_normalizer RTL.
`default_nettype none

module command_line_normalizer_test;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } line_word_t;

  logic clk_i;
  logic rst_ni;

  cln_in_if  in_if ();
  cln_out_if out_if ();

  command_line_normalizer i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  line_word_t expected_words[$];
  int unsigned mismatch_count;
  int unsigned random_sent;
  bit          gaps_on;
  bit          stalls_on;

  // Line state of the predictor.
  logic [7:0] held_char;
  logic       held_valid;
  logic       held_first;
  logic [7:0] prev_char;
  logic       in_comment;
  logic [7:0] last_out;
  logic       any_out;

  // Words produced by the current input word.
  logic [7:0] step_ch[8];
  logic       step_last[8];
  int         step_n;

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void clear_line();
    held_char  = 8'h00;
    held_valid = 1'b0;
    held_first = 1'b1;
    prev_char  = 8'h00;
    in_comment = 1'b0;
    last_out   = 8'h00;
    any_out    = 1'b0;
  endfunction

  function automatic void put_char(input logic [7:0] c);
    if (step_n < 8) begin
      step_ch[step_n]   = c;
      step_last[step_n] = 1'b0;
    end
    step_n++;
    last_out = c;
    any_out  = 1'b1;
  endfunction

  function automatic void place_char(input logic [7:0] c, input logic [7:0] p,
                                     input logic [7:0] s, input logic first,
                                     input logic at_end);
    logic pre;
    logic post;
    pre  = 1'b0;
    post = 1'b0;
    if (c == cln_pkg::CharSpace) begin
      if (!(first || p == cln_pkg::CharSpace)) put_char(c);
      return;
    end
    if (c == cln_pkg::CharLt || c == cln_pkg::CharSemi) begin
      pre  = !first && p != cln_pkg::CharSpace;
      post = !at_end && s != cln_pkg::CharSpace;
    end else if (c == cln_pkg::CharGt || c == cln_pkg::CharPipe) begin
      pre  = !first && p != cln_pkg::CharSpace && p != c;
      post = !at_end && s != cln_pkg::CharSpace && s != c;
    end else if (c == cln_pkg::CharAmp) begin
      pre  = !first && p != cln_pkg::CharSpace && (at_end || s == cln_pkg::CharAmp);
      post = !first && !at_end && s != cln_pkg::CharSpace && p == cln_pkg::CharAmp;
    end else begin
      put_char(c);
      return;
    end
    if (pre) put_char(cln_pkg::CharSpace);
    put_char(c);
    if (post) put_char(cln_pkg::CharSpace);
  endfunction

  function automatic void predict_line_words(input logic [7:0] b, input logic at_end);
    step_n = 0;
    if (!in_comment) begin
      if (held_valid) begin
        place_char(held_char, prev_char, b, held_first, 1'b0);
        prev_char  = held_char;
        held_first = 1'b0;
        held_valid = 1'b0;
      end
      if (b == cln_pkg::CharHash) begin
        in_comment = 1'b1;
        if (step_n > 0 && any_out && last_out == cln_pkg::CharNl) begin
          step_last[step_n-1] = 1'b1;
        end
      end else begin
        held_char  = b;
        held_valid = 1'b1;
      end
    end
    if (at_end) begin
      if (held_valid) place_char(held_char, prev_char, 8'h00, held_first, 1'b1);
      if (!any_out || last_out != cln_pkg::CharNl) put_char(cln_pkg::CharNl);
      if (step_n > 0) step_last[step_n-1] = 1'b1;
      clear_line();
    end
    for (int i = 0; i < step_n; i++) begin
      expected_words.push_back('{ch: step_ch[i], last: step_last[i]});
    end
  endfunction

  task automatic send_word(input logic [7:0] b, input logic at_end);
    int gap;
    gap = gaps_on ? $urandom_range(0, 16) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid   = 1'b1;
    in_if.in_byte = b;
    in_if.in_last = at_end;
    do @(posedge clk_i); while (!in_if.ready);
    predict_line_words(b, at_end);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_word(s[i], i == s.len() - 1);
    end
  endtask

  task automatic drain_output();
    @(negedge clk_i);
    in_if.valid = 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic note_mismatch(input string what, input line_word_t exp_w,
                               input line_word_t act_w);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("Mismatch (%s): expected byte %h last %b, got byte %h last %b",
               what, exp_w.ch, exp_w.last, act_w.ch, act_w.last);
    end
  endtask

  // Receiver: while stalls are on, stalls a random number of cycles before each word.
  initial begin
    int stall;
    out_if.ready = 1'b0;
    forever begin
      stall = stalls_on ? $urandom_range(0, 16) : 0;
      @(negedge clk_i);
      if (stall > 0) begin
        out_if.ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_if.ready = 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
    end
  end

  always @(posedge clk_i) begin
    line_word_t act_w;
    line_word_t exp_w;
    if (rst_ni && out_if.valid && out_if.ready) begin
      act_w = '{ch: out_if.out_byte, last: out_if.out_last};
      if (expected_words.size() == 0) begin
        note_mismatch("unexpected word", '0, act_w);
      end else begin
        exp_w = expected_words.pop_front();
        if (act_w.ch != exp_w.ch) note_mismatch("out_byte", exp_w, act_w);
        if (act_w.last != exp_w.last) note_mismatch("out_last", exp_w, act_w);
      end
    end
  end

  task automatic test_basic_text();
    send_text("a");
    send_text(" a  #c");
    send_text(" ");
  endtask

  task automatic test_operators();
    send_text("a|b");
    send_text("x>>y");
    send_text("p&&q&");
    send_text("<;");
  endtask

  task automatic test_comments();
    send_text("\n#");
    drain_output();
  endtask

  task automatic test_edge_bytes();
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(cln_pkg::CharNl, 1'b1);
  endtask

  task automatic test_random_lines();
    int len;
    int pick;
    int line_count;
    bit noise;
    logic [7:0] c;
    logic [7:0] prev;
    line_count = 0;
    while (random_sent < 100) begin
      if (line_count % 8 == 0) begin
        gaps_on   = $urandom_range(0, 3) != 0;
        stalls_on = $urandom_range(0, 3) != 0;
      end
      if (line_count == 12) drain_output();
      len    = $urandom_range(1, 8);
      noise  = $urandom_range(0, 9) == 0;
      prev   = cln_pkg::CharSpace;
      for (int i = 0; i < len; i++) begin
        pick = $urandom_range(0, 15);
        if (noise) begin
          c = 8'($urandom_range(0, 255));
        end else if (pick <= 5) begin
          c = 8'($urandom_range(8'h61, 8'h7A));
        end else if (pick <= 7) begin
          c = cln_pkg::CharSpace;
        end else if (pick == 8) begin
          c = cln_pkg::CharLt;
        end else if (pick == 9) begin
          c = cln_pkg::CharSemi;
        end else if (pick == 10) begin
          c = cln_pkg::CharPipe;
        end else if (pick == 11) begin
          c = cln_pkg::CharGt;
        end else if (pick == 12) begin
          c = cln_pkg::CharAmp;
        end else if (pick == 13) begin
          c = prev;
        end else if (pick == 14) begin
          c = cln_pkg::CharNl;
        end else begin
          c = ($urandom_range(0, 2) == 0) ? cln_pkg::CharHash : 8'($urandom_range(0, 255));
        end
        prev = c;
        random_sent++;
        send_word(c, i == len - 1);
      end
      line_count++;
    end
  endtask

  initial begin
    int unsigned guard;
    in_if.valid    = 1'b0;
    in_if.in_byte  = 8'h00;
    in_if.in_last  = 1'b0;
    rst_ni         = 1'b0;
    mismatch_count = 0;
    random_sent    = 0;
    gaps_on        = 1'b1;
    stalls_on      = 1'b1;
    clear_line();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_basic_text();
    test_operators();
    test_comments();
    test_edge_bytes();
    test_random_lines();

    @(negedge clk_i);
    in_if.valid = 1'b0;
    guard = 0;
    while (expected_words.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0 && expected_words.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire
